[sv/abp_pkg.sv]
// abp_pkg: shared constants, types and helpers for the ARGB alpha blend block.
// Used by abp_lane, abp_merge and argb_alpha_blend_pixel. No dependencies.
package abp_pkg;

   // destination formats
   localparam logic [1:0] FMT_XRGB32 = 2'd0;
   localparam logic [1:0] FMT_RGB24  = 2'd1;
   localparam logic [1:0] FMT_RGB565 = 2'd2;
   localparam logic [1:0] FMT_UNUSED = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_GLOBAL_ALPHA = 2'd0;
   localparam logic [1:0] CSR_DEST_FORMAT  = 2'd1;
   localparam logic [1:0] CSR_ALPHA_ACCUM  = 2'd2;

   localparam logic [7:0] GLOBAL_ALPHA_RST = 8'hff;
   localparam logic [7:0] CHAN_MAX         = 8'hff;

   // number of lanes: blue, green, red, alpha
   localparam int NUM_LANES  = 4;
   localparam int LANE_ALPHA = 3;

   // floor(n / 65025) by reciprocal multiply plus one correction step
   localparam int            DIV_SHIFT = 40;
   localparam logic [15:0]   DIVISOR   = 16'd65025;
   localparam logic [24:0]   RECIP     = 25'((64'd1 << DIV_SHIFT) / 64'd65025);
   localparam int            NUM_W     = 24;
   localparam int            PROD_W    = NUM_W + 25;

   typedef struct packed {
      logic       neg;    // destination above source: subtract
      logic [7:0] base;   // destination channel
      logic       sat;    // saturate on overflow (alpha accumulate)
   } lane_meta_type;

   typedef struct packed {
      logic [7:0]    mag;  // |s - d|
      lane_meta_type meta;
   } lane_in_type;

   typedef struct packed {
      logic        vld;
      logic        byp;        // pixel bypasses the blend
      logic [31:0] byp_pixel;
      logic [1:0]  fmt;
      logic        acc;
   } merge_ctl_type;

   function automatic logic [31:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      logic [31:0] res;
      res = {16'd0, r[7:3], g[7:2], b[7:3]};
      return res;
   endfunction

endpackage

[sv/abp_lane.sv]
// abp_lane: one channel of the blend, d + trunc((s-d)*w/65025), four stages.
// Depends on abp_pkg for the divider constants and lane types.
module abp_lane (
   input  logic                 clock,
   input  logic                 en,
   input  abp_pkg::lane_in_type lane_in,
   input  logic [15:0]          weight,
   output logic [7:0]           result
);

   logic [abp_pkg::NUM_W-1:0]  num_ff;
   abp_pkg::lane_meta_type     meta2_ff;
   logic [abp_pkg::NUM_W-1:0]  num3_ff;
   logic [7:0]                 qest_ff;
   abp_pkg::lane_meta_type     meta3_ff;
   logic [7:0]                 quot_ff;
   abp_pkg::lane_meta_type     meta4_ff;
   logic [7:0]                 result_ff;

   logic [abp_pkg::PROD_W-1:0] prod;
   logic [abp_pkg::NUM_W-1:0]  qden;
   logic [abp_pkg::NUM_W-1:0]  rem;
   logic [7:0]                 quot_in;
   logic [8:0]                 sum;
   logic [7:0]                 result_in;

   assign prod    = abp_pkg::PROD_W'(num_ff) * abp_pkg::PROD_W'(abp_pkg::RECIP);
   assign qden    = abp_pkg::NUM_W'(qest_ff) * abp_pkg::NUM_W'(abp_pkg::DIVISOR);
   assign rem     = num3_ff - qden;
   // estimate is low by at most one
   assign quot_in = qest_ff + 8'(rem >= abp_pkg::NUM_W'(abp_pkg::DIVISOR));
   assign sum     = {1'b0, meta4_ff.base} + {1'b0, quot_ff};

   always_comb begin
      if (meta4_ff.neg) begin
         result_in = meta4_ff.base - quot_ff;
      end else if (meta4_ff.sat && sum[8]) begin
         result_in = abp_pkg::CHAN_MAX;
      end else begin
         result_in = sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= abp_pkg::NUM_W'(lane_in.mag) * abp_pkg::NUM_W'(weight);
         meta2_ff  <= lane_in.meta;
         num3_ff   <= num_ff;
         qest_ff   <= prod[abp_pkg::DIV_SHIFT +: 8];
         meta3_ff  <= meta2_ff;
         quot_ff   <= quot_in;
         meta4_ff  <= meta3_ff;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[sv/abp_merge.sv]
// abp_merge: packs the lane results into the destination format and holds
// the result beat. Depends on abp_pkg for format codes and pack565.
module abp_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  abp_pkg::merge_ctl_type ctl,
   input  logic [7:0]             lane_res [abp_pkg::NUM_LANES],
   output logic                   rsp_tvalid,
   output logic [31:0]            rsp_tdata
);

   logic        rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;
   logic [31:0] pixel_in;
   logic [7:0]  alpha;

   assign alpha = ctl.acc ? lane_res[abp_pkg::LANE_ALPHA] : 8'd0;

   always_comb begin
      case (ctl.fmt)
         abp_pkg::FMT_XRGB32: begin
            pixel_in = {alpha, lane_res[2], lane_res[1], lane_res[0]};
         end
         abp_pkg::FMT_RGB24: begin
            pixel_in = {8'd0, lane_res[2], lane_res[1], lane_res[0]};
         end
         abp_pkg::FMT_RGB565: begin
            pixel_in = abp_pkg::pack565(lane_res[2], lane_res[1], lane_res[0]);
         end
         default: begin
            pixel_in = ctl.byp_pixel;
         end
      endcase
      if (ctl.byp) begin
         pixel_in = ctl.byp_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= pixel_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[sv/argb_alpha_blend_pixel.sv]
// argb_alpha_blend_pixel: top level, configuration registers, operand stage,
// four channel lanes and the merge stage. Depends on abp_pkg, abp_lane, abp_merge.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | req_tdata: src_pixel 31:0, dest_pixel 63:32
//   rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: new_dest_pixel 31:0
//   csr     | in  | csr_we                 | csr_index, csr_wdata
//
// One beat per cycle sustained while no result is held; rsp_tvalid rises once a beat
// has passed the operand stage, four lane stages and output register (six registers).
// The lane multiplier chain sets the latency, the single pipeline enable the rate.
// A held result with rsp_tready low freezes the whole pipe and drops req_tready.
// Reset clears all stage valids and loads global_alpha 255, format xRGB,
// accumulate off.
module argb_alpha_blend_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // src_pixel 31:0, dest_pixel 63:32
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // new_dest_pixel 31:0
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int DLY = 5;  // operand stage plus four lane stages

   logic [7:0] ga_ff;
   logic [1:0] fmt_ff;
   logic       acc_ff;

   logic                 en;
   logic [DLY-1:0]       vld_ff;
   logic [DLY-1:0]       byp_ff;
   logic [31:0]          byp_pixel_ff [DLY];
   logic [15:0]          weight_ff;
   abp_pkg::lane_in_type lane_ff [abp_pkg::NUM_LANES];

   logic [31:0]          src;
   logic [31:0]          dst;
   logic [7:0]           src_a;
   logic [7:0]           s_ch [3];
   logic [7:0]           d_ch [3];
   logic                 copy;
   logic                 byp_in;
   logic [31:0]          byp_pixel_in;
   abp_pkg::lane_in_type lane_in [abp_pkg::NUM_LANES];
   logic [7:0]           lane_res [abp_pkg::NUM_LANES];
   abp_pkg::merge_ctl_type ctl;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ga_ff  <= abp_pkg::GLOBAL_ALPHA_RST;
         fmt_ff <= abp_pkg::FMT_XRGB32;
         acc_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            abp_pkg::CSR_GLOBAL_ALPHA: ga_ff  <= csr_wdata;
            abp_pkg::CSR_DEST_FORMAT:  fmt_ff <= csr_wdata[1:0];
            abp_pkg::CSR_ALPHA_ACCUM:  acc_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // operand unpack
   assign src     = req_tdata[31:0];
   assign dst     = req_tdata[63:32];
   assign src_a   = src[31:24];
   assign s_ch[0] = src[7:0];
   assign s_ch[1] = src[15:8];
   assign s_ch[2] = src[23:16];
   assign copy    = (src_a == abp_pkg::CHAN_MAX) && (ga_ff == abp_pkg::CHAN_MAX);

   always_comb begin
      if (fmt_ff == abp_pkg::FMT_RGB565) begin
         d_ch[0] = {dst[4:0], 3'b000};
         d_ch[1] = {dst[10:5], 2'b00};
         d_ch[2] = {dst[15:11], 3'b000};
      end else begin
         d_ch[0] = dst[7:0];
         d_ch[1] = dst[15:8];
         d_ch[2] = dst[23:16];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lane_in[i].meta.neg  = d_ch[i] > s_ch[i];
         lane_in[i].meta.base = d_ch[i];
         lane_in[i].meta.sat  = 1'b0;
         lane_in[i].mag       = (d_ch[i] > s_ch[i]) ? (d_ch[i] - s_ch[i])
                                                    : (s_ch[i] - d_ch[i]);
      end
      // alpha lane: trunc(255*a*ga/65025) added to destination alpha
      lane_in[abp_pkg::LANE_ALPHA].mag       = abp_pkg::CHAN_MAX;
      lane_in[abp_pkg::LANE_ALPHA].meta.neg  = 1'b0;
      lane_in[abp_pkg::LANE_ALPHA].meta.base = dst[31:24];
      lane_in[abp_pkg::LANE_ALPHA].meta.sat  = 1'b1;
   end

   // transparent source, opaque copy and unused format skip the blend
   always_comb begin
      byp_in       = 1'b1;
      byp_pixel_in = dst;
      case (fmt_ff)
         abp_pkg::FMT_XRGB32: begin
            byp_in       = (src_a == 8'd0) || copy;
            byp_pixel_in = copy ? src : dst;
         end
         abp_pkg::FMT_RGB24: begin
            byp_in       = (src_a == 8'd0) || copy;
            byp_pixel_in = copy ? {8'd0, src[23:0]} : {8'd0, dst[23:0]};
         end
         abp_pkg::FMT_RGB565: begin
            byp_in       = (src_a == 8'd0) || copy;
            byp_pixel_in = copy ? abp_pkg::pack565(s_ch[2], s_ch[1], s_ch[0])
                                : {16'd0, dst[15:0]};
         end
         default: begin
            byp_in       = 1'b1;
            byp_pixel_in = dst;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DLY-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff       <= 16'(src_a) * 16'(ga_ff);
         lane_ff         <= lane_in;
         byp_ff          <= {byp_ff[DLY-2:0], byp_in};
         byp_pixel_ff[0] <= byp_pixel_in;
         for (int i = 1; i < DLY; i++) begin
            byp_pixel_ff[i] <= byp_pixel_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < abp_pkg::NUM_LANES; g++) begin : gen_lane
      abp_lane u_lane (
         .clock   (clock),
         .en      (en),
         .lane_in (lane_ff[g]),
         .weight  (weight_ff),
         .result  (lane_res[g])
      );
   end

   assign ctl.vld       = vld_ff[DLY-1];
   assign ctl.byp       = byp_ff[DLY-1];
   assign ctl.byp_pixel = byp_pixel_ff[DLY-1];
   assign ctl.fmt       = fmt_ff;
   assign ctl.acc       = acc_ff;

   abp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .ctl        (ctl),
      .lane_res   (lane_res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
